// ===== sv/terminal_key_escape_decoder_core_assert.svh =====
// Assertion macros for the terminal key escape decoder checker
`ifndef TERMINAL_KEY_ESCAPE_DECODER_CORE_ASSERT_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define TKED_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tked assertion failed");

// next-cycle implication
`define TKED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tked assertion failed");

`endif

// ===== sv/tked_pkg.sv =====
// Shared types, codes and tables of the terminal key escape decoder
package tked_pkg;

	localparam int MaxParams = 3;
	localparam int QDepth = 2;

	localparam logic [1:0] ST_KEY = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	localparam logic [7:0] ESC_CODE = 8'd27;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	localparam logic [4:0] K_UP = 5'd0;
	localparam logic [4:0] K_END = 5'd5;
	localparam logic [4:0] K_HOME = 5'd7;
	localparam logic [4:0] K_INSERT = 5'd8;
	localparam logic [4:0] K_DELETE = 5'd9;
	localparam logic [4:0] K_PGUP = 5'd10;
	localparam logic [4:0] K_PGDN = 5'd11;
	localparam logic [4:0] K_ENTER = 5'd12;
	localparam logic [4:0] K_F1 = 5'd13;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       eod;
		logic       is_digit;
		logic [3:0] digit;
	} tok_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_named;
		logic [20:0] key_value;
		logic        shift;
		logic        meta;
		logic        ctrl;
		logic [7:0]  consumed;
	} res_t;

	// key number plus one for each tilde code, zero where no key
	function automatic logic [4:0] tilde_key(input logic [20:0] code);
		logic [4:0] k;
		k = 5'd0;
		if (code < 21'd25) begin
			case (code[4:0])
				5'd1: k = K_HOME + 5'd1;
				5'd2: k = K_INSERT + 5'd1;
				5'd3: k = K_DELETE + 5'd1;
				5'd4: k = K_END + 5'd1;
				5'd5: k = K_PGUP + 5'd1;
				5'd6: k = K_PGDN + 5'd1;
				5'd7: k = K_HOME + 5'd1;
				5'd8: k = K_END + 5'd1;
				5'd11: k = K_F1 + 5'd1;
				5'd12: k = K_F1 + 5'd2;
				5'd13: k = K_F1 + 5'd3;
				5'd14: k = K_F1 + 5'd4;
				5'd15: k = K_F1 + 5'd5;
				5'd17: k = K_F1 + 5'd6;
				5'd18: k = K_F1 + 5'd7;
				5'd19: k = K_F1 + 5'd8;
				5'd20: k = K_F1 + 5'd9;
				5'd21: k = K_F1 + 5'd10;
				5'd23: k = K_F1 + 5'd11;
				5'd24: k = K_F1 + 5'd12;
				default: k = 5'd0;
			endcase
		end
		return k;
	endfunction

	// modifier parameter 2..8 maps to shift/meta/ctrl bits, zero otherwise
	function automatic logic [2:0] dec_mods(input logic [20:0] n);
		logic [2:0] m;
		m = 3'd0;
		if (n >= 21'd2 && n <= 21'd8)
			m = 3'(n - 21'd1);
		return m;
	endfunction

endpackage

// ===== sv/terminal_key_escape_decoder_core.sv =====
// Terminal key escape decoder top level. Bytes enter a two-entry queue and
// are parsed one per cycle while the result queue has room; a parsed
// sequence end, a rejected byte or an end-of-data byte mid-sequence writes
// one transaction into a two-entry result queue. Sustained rate is one byte
// per cycle, limited by the combinational parse step (a multiply-by-ten
// accumulate of the running parameter). A result enters the result queue as
// the parser takes its last byte and shows on the ports once older results are popped.
module terminal_key_escape_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        end_of_data,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic        is_named,
	output logic [20:0] key_value,
	output logic        shift,
	output logic        meta,
	output logic        ctrl,
	output logic [7:0]  consumed
);
	import tked_pkg::*;

	logic tok_valid;
	logic tok_take;
	tok_t tok;
	logic res_full;
	logic res_push;
	res_t res;
	res_t rout;

	tked_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.in_byte(in_byte), .end_of_data(end_of_data),
		.tok_valid(tok_valid), .tok(tok), .tok_take(tok_take)
	);

	tked_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(tok_valid), .tok(tok),
		.tok_take(tok_take), .res_full(res_full), .res_push(res_push), .res(res)
	);

	tked_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .wdata(res), .full(res_full),
		.pop(pop), .empty(empty), .rdata(rout)
	);

	assign status = rout.status;
	assign is_named = rout.is_named;
	assign key_value = rout.key_value;
	assign shift = rout.shift;
	assign meta = rout.meta;
	assign ctrl = rout.ctrl;
	assign consumed = rout.consumed;
endmodule

// ===== sv/tked_front.sv =====
// Front end: input queue that classifies each byte into a token
module tked_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    in_byte,
	input  logic          end_of_data,
	output logic          tok_valid,
	output tked_pkg::tok_t tok,
	input  logic          tok_take
);
	import tked_pkg::*;

	tok_t       mem_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;
	tok_t       wtok;

	always_comb begin
		wtok.in_byte = in_byte;
		wtok.eod = end_of_data;
		wtok.is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
		wtok.digit = 4'(in_byte - 8'h30);
	end

	assign full = (cnt_q == 2'(QDepth));
	assign wr_en = push && !full;
	assign tok_valid = (cnt_q != 2'd0);
	assign rd_en = tok_valid && tok_take;
	assign tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wtok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

// ===== sv/tked_back.sv =====
// Back end: escape sequence parser, one token per cycle while the result queue is not full
module tked_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  tked_pkg::tok_t tok,
	output logic           tok_take,
	input  logic           res_full,
	output logic           res_push,
	output tked_pkg::res_t res
);
	import tked_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ESC = 3'd1;
	localparam logic [2:0] PH_SS3 = 3'd2;
	localparam logic [2:0] PH_CSI = 3'd3;
	localparam logic [2:0] PH_LINUX = 3'd4;
	localparam logic [2:0] PH_NUM = 3'd5;

	logic [2:0]  phase_q;
	logic [20:0] ps_q [MaxParams];
	logic [1:0]  pcnt_q;
	logic [20:0] run_q;
	logic        dseen_q;
	logic [7:0]  bcnt_q;

	logic [2:0]  phase_d;
	logic [1:0]  pcnt_d;
	logic [20:0] run_d;
	logic        dseen_d;
	logic [7:0]  bcnt_d;
	logic        ps_we;
	logic        clr;
	logic        done;
	res_t        r;
	logic [7:0]  b;
	logic [24:0] v;
	logic [20:0] fp0, fp1, fp2;
	logic [1:0]  n;
	logic [2:0]  mods;
	logic [20:0] okey;
	logic [4:0]  tk;
	logic        fin;

	assign tok_take = tok_valid && !res_full;
	assign b = tok.in_byte;

	always_comb begin
		phase_d = phase_q;
		pcnt_d = pcnt_q;
		run_d = run_q;
		dseen_d = dseen_q;
		bcnt_d = (bcnt_q == 8'hFF) ? bcnt_q : bcnt_q + 8'd1;
		ps_we = 1'b0;
		clr = 1'b0;
		done = 1'b0;
		r = '0;
		v = ({4'd0, run_q} << 3) + ({4'd0, run_q} << 1) + {21'd0, tok.digit};
		fp0 = (dseen_q && pcnt_q == 2'd0) ? run_q : ps_q[0];
		fp1 = (dseen_q && pcnt_q == 2'd1) ? run_q : ps_q[1];
		fp2 = (dseen_q && pcnt_q == 2'd2) ? run_q : ps_q[2];
		n = pcnt_q + 2'(dseen_q);
		mods = 3'd0;
		okey = 21'd0;
		tk = 5'd0;
		fin = 1'b0;

		if (phase_q == PH_IDLE && b != ESC_CODE) begin
			done = 1'b1;
			r.status = ST_REJECT;
		end else begin
			case (phase_q)
				PH_IDLE: phase_d = PH_ESC;
				PH_ESC: begin
					if (b == 8'h4F)
						phase_d = PH_SS3;
					else if (b == 8'h5B)
						phase_d = PH_CSI;
					else begin
						done = 1'b1;
						r.status = ST_REJECT;
					end
				end
				PH_SS3: begin
					done = 1'b1;
					r.is_named = 1'b1;
					if (b inside {8'h41, 8'h42, 8'h43, 8'h44, 8'h46, 8'h48})
						r.key_value = 21'(K_UP) + 21'(b - 8'h41);
					else if (b == 8'h4D)
						r.key_value = 21'(K_ENTER);
					else if (b inside {[8'h50:8'h53]})
						r.key_value = 21'(K_F1) + 21'(b - 8'h50);
					else if (b == 8'h58) begin
						r.is_named = 1'b0;
						r.key_value = 21'h3D;
					end else if (b == 8'h20) begin
						r.is_named = 1'b0;
						r.key_value = 21'h20;
					end else if (b inside {[8'h61:8'h64]}) begin
						r.key_value = 21'(K_UP) + 21'(b - 8'h61);
						r.ctrl = 1'b1;
					end else if (b == 8'h49 || b inside {[8'h6A:8'h79]}) begin
						r.is_named = 1'b0;
						r.key_value = 21'(b - 8'd64);
					end else begin
						r = '0;
						r.status = ST_REJECT;
					end
				end
				PH_CSI: begin
					if (b == 8'h5B)
						phase_d = PH_LINUX;
					else if (tok.is_digit) begin
						phase_d = PH_NUM;
						run_d = 21'(tok.digit);
						dseen_d = 1'b1;
						pcnt_d = 2'd0;
					end else begin
						done = 1'b1;
						r.is_named = 1'b1;
						if (b inside {8'h41, 8'h42, 8'h43, 8'h44, 8'h46, 8'h48})
							r.key_value = 21'(K_UP) + 21'(b - 8'h41);
						else if (b inside {[8'h61:8'h64]}) begin
							r.key_value = 21'(K_UP) + 21'(b - 8'h61);
							r.shift = 1'b1;
						end else if (b == 8'h4C)
							r.key_value = 21'(K_INSERT);
						else if (b == 8'h5A) begin
							r.is_named = 1'b0;
							r.key_value = 21'd9;
							r.shift = 1'b1;
						end else begin
							r = '0;
							r.status = ST_REJECT;
						end
					end
				end
				PH_LINUX: begin
					done = 1'b1;
					if (b inside {[8'h41:8'h45]}) begin
						r.is_named = 1'b1;
						r.key_value = 21'(K_F1) + 21'(b - 8'h41);
					end else
						r.status = ST_REJECT;
				end
				PH_NUM: begin
					if (tok.is_digit) begin
						if (v > {4'd0, CP_MAX}) begin
							done = 1'b1;
							r.status = ST_REJECT;
						end else begin
							run_d = v[20:0];
							dseen_d = 1'b1;
						end
					end else if (b == 8'h3B) begin
						if (pcnt_q >= 2'(MaxParams - 1)) begin
							done = 1'b1;
							r.status = ST_REJECT;
						end else begin
							ps_we = 1'b1;
							pcnt_d = pcnt_q + 2'd1;
							run_d = 21'd0;
							dseen_d = 1'b0;
						end
					end else if (b inside {8'h41, 8'h42, 8'h43, 8'h44, 8'h46, 8'h48,
							8'h50, 8'h51, 8'h52, 8'h53, 8'h75, 8'h7E}) begin
						done = 1'b1;
						r.status = ST_REJECT;
						if (n == 2'd3) begin
							mods = dec_mods(fp1);
							if (fp0 == 21'd27 && b == 8'h7E && mods != 3'd0) begin
								fin = 1'b1;
								okey = fp2;
							end
						end else if (n == 2'd2) begin
							mods = dec_mods(fp1);
							if (mods != 3'd0) begin
								if (b == 8'h7E) begin
									tk = tilde_key(fp0);
									if (tk != 5'd0) begin
										r.status = ST_KEY;
										r.is_named = 1'b1;
										r.key_value = 21'(tk - 5'd1);
										{r.ctrl, r.meta, r.shift} = mods;
									end
								end else if (b == 8'h75) begin
									fin = 1'b1;
									okey = fp0;
								end else if (fp0 == 21'd1) begin
									r.status = ST_KEY;
									r.is_named = 1'b1;
									{r.ctrl, r.meta, r.shift} = mods;
									if (b inside {[8'h50:8'h53]})
										r.key_value = 21'(K_F1) + 21'(b - 8'h50);
									else
										r.key_value = 21'(K_UP) + 21'(b - 8'h41);
								end
							end
						end else if (n == 2'd1 && b == 8'h7E) begin
							tk = tilde_key(fp0);
							if (tk != 5'd0) begin
								r.status = ST_KEY;
								r.is_named = 1'b1;
								r.key_value = 21'(tk - 5'd1);
							end
						end
						if (fin) begin
							r.status = ST_KEY;
							r.is_named = 1'b0;
							if (okey > 21'h20 && okey < 21'h80) begin
								mods[0] = 1'b0;
								if (mods[2] && okey >= 21'h61 && okey <= 21'h7A)
									okey = okey - 21'h20;
							end
							r.key_value = okey;
							{r.ctrl, r.meta, r.shift} = mods;
						end
					end else begin
						done = 1'b1;
						r.status = ST_REJECT;
					end
				end
				default: begin
					done = 1'b1;
					r.status = ST_REJECT;
				end
			endcase
			if (done && r.status == ST_KEY)
				r.consumed = bcnt_d;
		end

		if (done)
			clr = 1'b1;
		else if (tok.eod) begin
			r = '0;
			r.status = ST_INCOMPLETE;
		end
	end

	assign res = r;
	assign res_push = tok_take && (done || tok.eod);

	always_ff @(posedge clk) begin
		if (tok_take && ps_we)
			ps_q[pcnt_q] <= run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pcnt_q <= 2'd0;
			run_q <= 21'd0;
			dseen_q <= 1'b0;
			bcnt_q <= 8'd0;
		end else if (tok_take) begin
			if (clr) begin
				phase_q <= PH_IDLE;
				pcnt_q <= 2'd0;
				run_q <= 21'd0;
				dseen_q <= 1'b0;
				bcnt_q <= 8'd0;
			end else begin
				phase_q <= phase_d;
				pcnt_q <= pcnt_d;
				run_q <= run_d;
				dseen_q <= dseen_d;
				bcnt_q <= bcnt_d;
			end
		end
	end
endmodule

// ===== sv/tked_outq.sv =====
// Result queue between the parser and the result ports
module tked_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  tked_pkg::res_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tked_pkg::res_t rdata
);
	import tked_pkg::*;

	res_t       mem_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign full = (cnt_q == 2'(QDepth));
	assign empty = (cnt_q == 2'd0);
	assign wr_en = wr && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

// ===== sv/tked_checker.sv =====
// Port-level checker for the terminal key escape decoder, with its bind
`include "terminal_key_escape_decoder_core_assert.svh"

module tked_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [20:0] key_value,
	input logic        is_named,
	input logic [7:0]  consumed
);
	import tked_pkg::*;

	`TKED_ASSERT_NXT(a_res_held, !empty && !pop, !empty)
	`TKED_ASSERT_NOW(a_status_code, !empty, status <= ST_INCOMPLETE)
	`TKED_ASSERT_NOW(a_reject_clean, !empty && status != ST_KEY,
		consumed == 8'd0 && key_value == 21'd0 && !is_named)
	`TKED_ASSERT_NOW(a_key_len, !empty && status == ST_KEY, consumed >= 8'd3)
	`TKED_ASSERT_NOW(a_named_range, !empty && is_named, key_value <= 21'd24)
endmodule

bind terminal_key_escape_decoder_core tked_checker u_tked_checker (.*);
